[rtl/linked_index_queue_top_assert.svh]
// Assertion macros for the linked index queue top level.
// Needs clk and rst_n in the scope of the including module.
`ifndef LINKED_INDEX_QUEUE_TOP_ASSERT_SVH
`define LINKED_INDEX_QUEUE_TOP_ASSERT_SVH

// cond implies prop in the same cycle
`define LIQ_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("linked index queue: assertion failed");

// cond implies prop in the next cycle
`define LIQ_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("linked index queue: assertion failed");

`endif

[rtl/liq_pkg.sv]
// Shared types, constants and helpers for the linked index queue.
// No dependencies; used by controller, datapath and top level.
package liq_pkg;

    localparam int POOL_SIZE = 1024;
    localparam int IDX_W     = 10;
    localparam int ADDR_W    = $clog2(POOL_SIZE);
    localparam int LINK_W    = IDX_W + 1;
    localparam int STEP_W    = $clog2(POOL_SIZE + 1);

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic none;
        idx_t idx;
    } link_t;

    localparam link_t LINK_NONE = '{none: 1'b1, idx: '1};

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_PUSH   = 3'd1;
    localparam logic [2:0] OP_INSERT = 3'd2;
    localparam logic [2:0] OP_POP    = 3'd3;
    localparam logic [2:0] OP_ERASE  = 3'd4;

    typedef enum logic [2:0] {
        WR_IDLE,
        WR_CLEAR,
        WR_OBJ_NONE,
        WR_OBJ_HEAD,
        WR_OBJ_RD,
        WR_AFT_OBJ,
        WR_TAIL_OBJ,
        WR_PREV_RD
    } wr_sel_t;

    typedef enum logic [2:0] {
        RD_IDLE,
        RD_AFT,
        RD_OBJ,
        RD_HEAD,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [1:0] {
        HD_KEEP,
        HD_OBJ,
        HD_RD,
        HD_NONE
    } head_sel_t;

    typedef enum logic [1:0] {
        TL_KEEP,
        TL_OBJ,
        TL_PREV,
        TL_NONE
    } tail_sel_t;

    typedef struct packed {
        logic      load;
        logic      clr_step;
        wr_sel_t   wr_sel;
        rd_sel_t   rd_sel;
        head_sel_t head_sel;
        tail_sel_t tail_sel;
        logic      walk_start;
        logic      walk_step;
        logic      ok_set;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic [2:0] op;
        logic       obj_ok;
        logic       aft_ok;
        logic       head_none;
        logic       tail_none;
        logic       obj_is_head;
        logic       obj_is_tail;
        logic       aft_is_tail;
        logic       rd_none;
        logic       rd_is_obj;
        logic       steps_max;
        logic       out_free;
    } sts_t;

    function automatic logic in_pool(idx_t i);
        return 32'(i) < POOL_SIZE;
    endfunction

    function automatic logic [ADDR_W-1:0] to_addr(idx_t i);
        return ADDR_W'(i);
    endfunction

endpackage

[rtl/linked_index_queue_top.sv]
// Top level of the linked index queue: controller plus datapath.
// Uses liq_pkg, liq_ctrl, liq_dpath and linked_index_queue_top_assert.svh.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------------
//  input    | in_valid / in_stall  | op, object_index, after_index
//  output   | out_valid / out_stall| status, popped_index, head_index, tail_index,
//           |                      | queue_empty
//
// One item at a time: the next item is accepted only after the last result is loaded.
// Push and early failures finish from dispatch; append, pop/erase of the head and insert
// write links first; erase of another object walks the links before its predecessor
// (one link RAM read per cycle). An erase whose walk misses reads at most 1025 links.
// After reset a clearing pass writes all 1024 links to none, input stalled.
// The result register lets the next item in while a result waits; a stalled output only
// holds the block once the following result is ready.
module linked_index_queue_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [2:0]    op,
    input  liq_pkg::idx_t object_index,
    input  liq_pkg::idx_t after_index,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          status,
    output liq_pkg::idx_t popped_index,
    output liq_pkg::idx_t head_index,
    output liq_pkg::idx_t tail_index,
    output logic          queue_empty
);

    liq_pkg::cmd_t cmd;
    liq_pkg::sts_t sts;

    liq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sts     (sts),
        .cmd     (cmd)
    );

    liq_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .op          (op),
        .object_index(object_index),
        .after_index (after_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .popped_index(popped_index),
        .head_index  (head_index),
        .tail_index  (tail_index),
        .queue_empty (queue_empty)
    );

`include "linked_index_queue_top_assert.svh"

    // a pending result is never overwritten
    `LIQ_ASSERT_NOW(a_out_load_free, cmd.out_load, sts.out_free)
    // one item in flight
    `LIQ_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)
    // no item taken while the link store is being cleared
    `LIQ_ASSERT_NOW(a_clear_stalls, cmd.wr_sel == liq_pkg::WR_CLEAR, in_stall)

endmodule

[rtl/liq_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module liq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/liq_ctrl.sv]
// Sequencer for the linked index queue: clear pass, op dispatch, link walk.
// Uses liq_pkg; drives the datapath through cmd_t, reads sts_t.
module liq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  liq_pkg::sts_t sts,
    output liq_pkg::cmd_t cmd
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_APP_W2   = 4'd3;
    localparam logic [3:0] S_INS_W1   = 4'd4;
    localparam logic [3:0] S_INS_W2   = 4'd5;
    localparam logic [3:0] S_HEAD_W   = 4'd6;
    localparam logic [3:0] S_WALK     = 4'd7;
    localparam logic [3:0] S_ERA_W1   = 4'd8;
    localparam logic [3:0] S_ERA_W2   = 4'd9;
    localparam logic [3:0] S_FINISH   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.clr_step   = 1'b0;
        cmd.wr_sel     = liq_pkg::WR_IDLE;
        cmd.rd_sel     = liq_pkg::RD_IDLE;
        cmd.head_sel   = liq_pkg::HD_KEEP;
        cmd.tail_sel   = liq_pkg::TL_KEEP;
        cmd.walk_start = 1'b0;
        cmd.walk_step  = 1'b0;
        cmd.ok_set     = 1'b0;
        cmd.out_load   = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_sel   = liq_pkg::WR_CLEAR;
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FINISH;
                unique case (sts.op)
                    liq_pkg::OP_APPEND:
                    begin
                        if (sts.obj_ok)
                        begin
                            cmd.wr_sel = liq_pkg::WR_OBJ_NONE;
                            state_next = S_APP_W2;
                        end
                    end
                    liq_pkg::OP_PUSH:
                    begin
                        if (sts.obj_ok)
                        begin
                            cmd.wr_sel   = liq_pkg::WR_OBJ_HEAD;
                            cmd.head_sel = liq_pkg::HD_OBJ;
                            if (sts.head_none)
                            begin
                                cmd.tail_sel = liq_pkg::TL_OBJ;
                            end
                            cmd.ok_set = 1'b1;
                        end
                    end
                    liq_pkg::OP_INSERT:
                    begin
                        if (sts.obj_ok && sts.aft_ok)
                        begin
                            cmd.rd_sel = liq_pkg::RD_AFT;
                            state_next = S_INS_W1;
                        end
                    end
                    liq_pkg::OP_POP:
                    begin
                        // object register already holds the head
                        if (!sts.head_none)
                        begin
                            cmd.rd_sel = liq_pkg::RD_OBJ;
                            state_next = S_HEAD_W;
                        end
                    end
                    liq_pkg::OP_ERASE:
                    begin
                        priority if (!sts.obj_ok)
                        begin
                            state_next = S_FINISH;
                        end
                        else if (sts.obj_is_head)
                        begin
                            cmd.rd_sel = liq_pkg::RD_OBJ;
                            state_next = S_HEAD_W;
                        end
                        else if (sts.head_none)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.rd_sel     = liq_pkg::RD_HEAD;
                            cmd.walk_start = 1'b1;
                            state_next     = S_WALK;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_APP_W2:
            begin
                if (sts.tail_none)
                begin
                    cmd.head_sel = liq_pkg::HD_OBJ;
                end
                else
                begin
                    cmd.wr_sel = liq_pkg::WR_TAIL_OBJ;
                end
                cmd.tail_sel = liq_pkg::TL_OBJ;
                cmd.ok_set   = 1'b1;
                state_next   = S_FINISH;
            end
            S_INS_W1:
            begin
                cmd.wr_sel = liq_pkg::WR_OBJ_RD;
                state_next = S_INS_W2;
            end
            S_INS_W2:
            begin
                cmd.wr_sel = liq_pkg::WR_AFT_OBJ;
                if (sts.aft_is_tail)
                begin
                    cmd.tail_sel = liq_pkg::TL_OBJ;
                end
                cmd.ok_set = 1'b1;
                state_next = S_FINISH;
            end
            S_HEAD_W:
            begin
                cmd.wr_sel   = liq_pkg::WR_OBJ_NONE;
                cmd.head_sel = liq_pkg::HD_RD;
                if (sts.rd_none)
                begin
                    cmd.tail_sel = liq_pkg::TL_NONE;
                end
                cmd.ok_set = 1'b1;
                state_next = S_FINISH;
            end
            S_WALK:
            begin
                // read data is the link of the current predecessor candidate
                priority if (sts.rd_is_obj)
                begin
                    cmd.rd_sel = liq_pkg::RD_OBJ;
                    state_next = S_ERA_W1;
                end
                else if (sts.steps_max || sts.rd_none)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rd_sel    = liq_pkg::RD_NEXT;
                    cmd.walk_step = 1'b1;
                end
            end
            S_ERA_W1:
            begin
                cmd.wr_sel = liq_pkg::WR_PREV_RD;
                state_next = S_ERA_W2;
            end
            S_ERA_W2:
            begin
                cmd.wr_sel = liq_pkg::WR_OBJ_NONE;
                if (sts.obj_is_tail)
                begin
                    cmd.tail_sel = liq_pkg::TL_PREV;
                end
                cmd.ok_set = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/liq_dpath.sv]
// Datapath for the linked index queue: link RAM, head/tail, walk and result registers.
// Uses liq_pkg and liq_ram; controlled by liq_ctrl through cmd_t.
module liq_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  liq_pkg::cmd_t        cmd,
    output liq_pkg::sts_t        sts,
    input  logic [2:0]           op,
    input  liq_pkg::idx_t        object_index,
    input  liq_pkg::idx_t        after_index,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 status,
    output liq_pkg::idx_t        popped_index,
    output liq_pkg::idx_t        head_index,
    output liq_pkg::idx_t        tail_index,
    output logic                 queue_empty
);

    logic [2:0]                      op_reg;
    liq_pkg::idx_t                   obj_reg;
    liq_pkg::idx_t                   aft_reg;
    liq_pkg::idx_t                   prev_reg;
    logic [liq_pkg::STEP_W-1:0]      steps_reg;
    logic                            ok_reg;
    liq_pkg::link_t                  head_reg;
    liq_pkg::link_t                  head_next;
    liq_pkg::link_t                  tail_reg;
    liq_pkg::link_t                  tail_next;
    logic [liq_pkg::ADDR_W-1:0]      clr_cnt_reg;
    logic                            out_valid_reg;
    logic                            status_reg;
    liq_pkg::idx_t                   popped_reg;
    liq_pkg::idx_t                   head_out_reg;
    liq_pkg::idx_t                   tail_out_reg;
    logic                            empty_reg;

    logic                            wr_en;
    logic [liq_pkg::ADDR_W-1:0]      wr_addr;
    liq_pkg::link_t                  wr_link;
    logic                            rd_en;
    logic [liq_pkg::ADDR_W-1:0]      rd_addr;
    logic [liq_pkg::LINK_W-1:0]      rd_word;
    liq_pkg::link_t                  rd_link;

    assign rd_link = liq_pkg::link_t'(rd_word);

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = liq_pkg::to_addr(obj_reg);
        wr_link = liq_pkg::LINK_NONE;
        unique case (cmd.wr_sel)
            liq_pkg::WR_IDLE:     wr_en = 1'b0;
            liq_pkg::WR_CLEAR:    wr_addr = clr_cnt_reg;
            liq_pkg::WR_OBJ_NONE: wr_link = liq_pkg::LINK_NONE;
            liq_pkg::WR_OBJ_HEAD: wr_link = head_reg;
            liq_pkg::WR_OBJ_RD:   wr_link = rd_link;
            liq_pkg::WR_AFT_OBJ:
            begin
                wr_addr = liq_pkg::to_addr(aft_reg);
                wr_link = '{none: 1'b0, idx: obj_reg};
            end
            liq_pkg::WR_TAIL_OBJ:
            begin
                wr_addr = liq_pkg::to_addr(tail_reg.idx);
                wr_link = '{none: 1'b0, idx: obj_reg};
            end
            liq_pkg::WR_PREV_RD:
            begin
                wr_addr = liq_pkg::to_addr(prev_reg);
                wr_link = rd_link;
            end
            default:              wr_en = 1'b0;
        endcase
    end

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = liq_pkg::to_addr(obj_reg);
        unique case (cmd.rd_sel)
            liq_pkg::RD_IDLE: rd_en = 1'b0;
            liq_pkg::RD_AFT:  rd_addr = liq_pkg::to_addr(aft_reg);
            liq_pkg::RD_OBJ:  rd_addr = liq_pkg::to_addr(obj_reg);
            liq_pkg::RD_HEAD: rd_addr = liq_pkg::to_addr(head_reg.idx);
            liq_pkg::RD_NEXT: rd_addr = liq_pkg::to_addr(rd_link.idx);
            default:          rd_en = 1'b0;
        endcase
    end

    liq_ram #(
        .WIDTH(liq_pkg::LINK_W),
        .DEPTH(liq_pkg::POOL_SIZE)
    ) u_link_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_link),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_word)
    );

    always_comb
    begin
        unique case (cmd.head_sel)
            liq_pkg::HD_KEEP: head_next = head_reg;
            liq_pkg::HD_OBJ:  head_next = '{none: 1'b0, idx: obj_reg};
            liq_pkg::HD_RD:   head_next = rd_link;
            liq_pkg::HD_NONE: head_next = liq_pkg::LINK_NONE;
            default:          head_next = head_reg;
        endcase
        unique case (cmd.tail_sel)
            liq_pkg::TL_KEEP: tail_next = tail_reg;
            liq_pkg::TL_OBJ:  tail_next = '{none: 1'b0, idx: obj_reg};
            liq_pkg::TL_PREV: tail_next = '{none: 1'b0, idx: prev_reg};
            liq_pkg::TL_NONE: tail_next = liq_pkg::LINK_NONE;
            default:          tail_next = tail_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= liq_pkg::LINK_NONE;
            tail_reg      <= liq_pkg::LINK_NONE;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + liq_pkg::ADDR_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            // pop works on the current head
            obj_reg <= (op == liq_pkg::OP_POP) ? head_reg.idx : object_index;
            aft_reg <= after_index;
            ok_reg  <= 1'b0;
        end
        else if (cmd.ok_set)
        begin
            ok_reg <= 1'b1;
        end
        if (cmd.walk_start)
        begin
            prev_reg  <= head_reg.idx;
            steps_reg <= '0;
        end
        else if (cmd.walk_step)
        begin
            prev_reg  <= rd_link.idx;
            steps_reg <= steps_reg + liq_pkg::STEP_W'(1);
        end
        if (cmd.out_load)
        begin
            status_reg   <= !ok_reg;
            popped_reg   <= (ok_reg && op_reg == liq_pkg::OP_POP) ? obj_reg : '0;
            head_out_reg <= head_reg.none ? '0 : head_reg.idx;
            tail_out_reg <= tail_reg.none ? '0 : tail_reg.idx;
            empty_reg    <= head_reg.none;
        end
    end

    assign sts.clr_last    = (clr_cnt_reg == liq_pkg::ADDR_W'(liq_pkg::POOL_SIZE - 1));
    assign sts.op          = op_reg;
    assign sts.obj_ok      = liq_pkg::in_pool(obj_reg);
    assign sts.aft_ok      = liq_pkg::in_pool(aft_reg);
    assign sts.head_none   = head_reg.none;
    assign sts.tail_none   = tail_reg.none;
    assign sts.obj_is_head = !head_reg.none && (head_reg.idx == obj_reg);
    assign sts.obj_is_tail = !tail_reg.none && (tail_reg.idx == obj_reg);
    assign sts.aft_is_tail = !tail_reg.none && (tail_reg.idx == aft_reg);
    assign sts.rd_none     = rd_link.none;
    assign sts.rd_is_obj   = !rd_link.none && (rd_link.idx == obj_reg);
    assign sts.steps_max   = (steps_reg == liq_pkg::STEP_W'(liq_pkg::POOL_SIZE));
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_index = popped_reg;
    assign head_index   = head_out_reg;
    assign tail_index   = tail_out_reg;
    assign queue_empty  = empty_reg;

endmodule
